/* design/mhpq_pkg.sv */
// Package for the max-heap priority queue: sizes, command and status codes.
// No dependencies; mhpq_if and max_heap_priority_queue import it.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  localparam logic [IDX_W-1:0] COUNT_FULL = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W-1:0] ROOT_SLOT  = IDX_W'(1);

endpackage

`default_nettype wire

/* design/mhpq_if.sv */
// Request and response channel interfaces of the max-heap priority queue.
// Depends on mhpq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mhpq_req_if
  import mhpq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface mhpq_rsp_if
  import mhpq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;
  logic [TOTAL_W-1:0]       entry_total;

  modport source (output valid, status, removed_value, entry_total, input ready);
  modport sink   (input valid, status, removed_value, entry_total, output ready);
endinterface

`default_nettype wire

/* design/mhpq_ram.sv */
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Generic; sized by its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/max_heap_priority_queue.sv */
// Max-heap priority queue of signed 32-bit values: sequencer over one heap RAM.
// Depends on mhpq_pkg, mhpq_req_if / mhpq_rsp_if and mhpq_ram.
//
//  - req channel: command (insert / remove max) and value. A request is taken
//    when req.valid and req.ready are both high at a rising edge of clk.
//  - rsp channel: status, removed_value, entry_total; one response per request,
//    in order, held in an output register until rsp.ready.
//  - One request is in work at a time; req.ready is high only while idle, and
//    the next request is taken while the previous response still waits.
//  - Steps: overflow / empty go straight to S_FINISH; insert climbs through
//    S_UP_RD / S_UP_CMP once per level, stopping at the root or at a parent
//    that is not smaller; remove reads the root and the last slot, then either
//    finishes, if that empties the heap, or sifts down through S_DN_RD_L /
//    S_DN_RD_R / S_DN_CMP to a leaf or until the compare stops it.
//  - The moving entry is held in a register ("hole" sift); each level reads the
//    neighbor (both children on the way down) and writes back one word.
//  - Reset (rst, synchronous): count cleared, no response pending; RAM is not
//    cleared, only data read from slots 1..count is used.
//  - A stalled rsp channel holds the finished response in S_FINISH until the
//    output register frees; req.ready stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_ROOT,
    S_RM_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_CMP,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         count;
  logic [IDX_W-1:0]         pos;
  logic signed [DATA_W-1:0] cur;       // entry being sifted
  logic signed [DATA_W-1:0] left_val;
  logic [STATUS_W-1:0]      res_status;
  logic signed [DATA_W-1:0] res_removed;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  mhpq_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_W)
  ) u_heap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // child indexes, one bit wider so 2*pos never wraps
  logic [IDX_W:0]           left_idx;
  logic [IDX_W:0]           right_idx;
  logic                     left_ok;
  logic                     right_ok;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] best_val;
  logic [IDX_W:0]           best_idx;
  logic                     best_is_cur;
  logic                     out_free;
  logic                     parent_less;

  assign left_idx  = {pos, 1'b0};
  assign right_idx = left_idx + 1'b1;
  assign left_ok   = (left_idx <= {1'b0, count});
  assign right_ok  = (right_idx <= {1'b0, count});
  assign rd_val    = $signed(ram_rdata);
  assign out_free  = !rsp.valid || rsp.ready;
  assign parent_less = (rd_val < cur);

  // larger-child pick; left wins ties, cur wins unless strictly smaller
  always_comb begin
    best_val    = cur;
    best_idx    = {1'b0, pos};
    best_is_cur = 1'b1;
    if (left_val > best_val) begin
      best_val    = left_val;
      best_idx    = left_idx;
      best_is_cur = 1'b0;
    end
    if (right_ok && (rd_val > best_val)) begin
      best_val    = rd_val;
      best_idx    = right_idx;
      best_is_cur = 1'b0;
    end
  end

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur;
    ram_raddr = ROOT_SLOT;
    unique case (state)
      S_IDLE:    ram_raddr = ROOT_SLOT;
      S_RM_ROOT: ram_raddr = count;
      S_UP_RD: begin
        ram_raddr = pos >> 1;
        ram_we    = (pos == ROOT_SLOT);
      end
      S_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = parent_less ? ram_rdata : cur;
      end
      S_DN_RD_L: begin
        ram_raddr = left_idx[IDX_W-1:0];
        ram_we    = !left_ok;
      end
      S_DN_RD_R: ram_raddr = right_idx[IDX_W-1:0];
      S_DN_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = best_val;
      end
      S_RM_LAST, S_FINISH: ram_raddr = ROOT_SLOT;
      default:   ram_raddr = ROOT_SLOT;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_status  <= STATUS_OK;
            res_removed <= '0;
            cur         <= req.value;
            if (req.command == CMD_INSERT) begin
              if (count >= COUNT_FULL) begin
                res_status <= STATUS_OVERFLOW;
                state      <= S_FINISH;
              end else begin
                count <= count + 1'b1;
                pos   <= count + 1'b1;
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= S_FINISH;
              end else begin
                state <= S_RM_ROOT;
              end
            end
          end
        end
        S_RM_ROOT: begin
          res_removed <= rd_val;
          state       <= S_RM_LAST;
        end
        S_RM_LAST: begin
          cur   <= rd_val;
          pos   <= ROOT_SLOT;
          count <= count - 1'b1;
          state <= (count == ROOT_SLOT) ? S_FINISH : S_DN_RD_L;
        end
        S_UP_RD: begin
          state <= (pos == ROOT_SLOT) ? S_FINISH : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (parent_less) begin
            pos   <= pos >> 1;
            state <= S_UP_RD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DN_RD_L: begin
          state <= left_ok ? S_DN_RD_R : S_FINISH;
        end
        S_DN_RD_R: begin
          left_val <= rd_val;
          state    <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (best_is_cur) begin
            state <= S_FINISH;
          end else begin
            pos   <= best_idx[IDX_W-1:0];
            state <= S_DN_RD_L;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.removed_value <= res_removed;
            rsp.entry_total   <= TOTAL_W'(count);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
